FILE: hdl/mvm_pkg.sv
// mvm_pkg: shared types, field widths and codes for the matrix vector multiplier
// no dependencies; imported by the interfaces, the controller and the datapath
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int VALUE_W = 32;
  localparam int ROW_W   = 9;
  localparam int SIZE_W  = 10;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [SIZE_W-1:0]         size_t;

  localparam size_t SIZE_RESET  = 10'd512;
  localparam logic  MODE_LOAD   = 1'b0;
  localparam logic  MODE_MATRIX = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic multiply;
    logic accumulate;
    logic emit;
  } mvm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic matrix_item;
    logic last_col;
  } mvm_status_t;

endpackage

FILE: hdl/mvm_if.sv
// mvm_item_if and mvm_result_if: valid/ready channels for input items and row results
// depends on mvm_pkg for the payload types
`timescale 1ns / 1ps

interface mvm_item_if;
  logic            valid;
  logic            ready;
  logic            mode;
  mvm_pkg::value_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface mvm_result_if;
  logic            valid;
  logic            ready;
  mvm_pkg::value_t result_value;
  mvm_pkg::row_t   row_index;
  logic            last_row;

  modport source (output valid, output result_value, output row_index, output last_row,
                  input ready);
  modport sink (input valid, input result_value, input row_index, input last_row,
                output ready);
endinterface

FILE: hdl/matrix_vector_multiply.sv
// matrix_vector_multiply: top level, streamed square integer matrix times stored vector
// depends on mvm_pkg, mvm_if, mvm_ctrl and mvm_datapath
//
//   channel  dir  request fields                          handshake
//   item     in   mode, value                             valid/ready
//   result   out  result_value, row_index, last_row       valid/ready
//   cfg      in   cfg_data (size_in_use)                  cfg_write, no wait
//
// a vector load request leaves the input open for the next request; a matrix request passes
// through a registered memory read, the multiplier register and the add into the running sum
// the add at a row end waits only while the result register is still occupied
// the result register lets the next request in while a row sum waits
// reset (synchronous, rst high) sets the order to 512 and clears the counters;
// the vector memory is not cleared
`timescale 1ns / 1ps

module matrix_vector_multiply #(
  parameter int MAX_N = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  mvm_pkg::size_t      cfg_data,
  mvm_item_if.sink            item,
  mvm_result_if.source        result
);
  import mvm_pkg::*;

  mvm_cmd_t    cmd;
  mvm_status_t status;

  mvm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  mvm_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item_mode    (item.mode),
    .item_value   (item.value),
    .cmd          (cmd),
    .status       (status),
    .result_value (result.result_value),
    .row_index    (result.row_index),
    .last_row     (result.last_row)
  );

endmodule

FILE: hdl/mvm_ctrl.sv
// mvm_ctrl: state machine that sequences one item at a time; matrix items go through read, multiply, add
// depends on mvm_pkg; drives the command struct of mvm_datapath
`timescale 1ns / 1ps

module mvm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  mvm_pkg::mvm_status_t status,
  output mvm_pkg::mvm_cmd_t    cmd
);
  import mvm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC
  } state_t;

  state_t state;
  logic   result_free;

  assign item_ready  = (state == S_IDLE);
  assign result_free = !result_valid || result_ready;

  always_comb begin
    cmd.capture    = item_valid && item_ready;
    cmd.multiply   = (state == S_MUL);
    cmd.accumulate = (state == S_ACC) && !status.last_col;
    // row end waits here until the output register can take the sum
    cmd.emit       = (state == S_ACC) && status.last_col && result_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.capture && status.matrix_item) state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (cmd.accumulate || cmd.emit) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.emit) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/mvm_datapath.sv
// mvm_datapath: vector memory, position counters, multiplier, running sum, result register
// depends on mvm_pkg; sequenced by mvm_ctrl through the command struct
`timescale 1ns / 1ps

module mvm_datapath #(
  parameter int MAX_N = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  mvm_pkg::size_t       cfg_data,
  input  logic                 item_mode,
  input  mvm_pkg::value_t      item_value,
  input  mvm_pkg::mvm_cmd_t    cmd,
  output mvm_pkg::mvm_status_t status,
  output mvm_pkg::value_t      result_value,
  output mvm_pkg::row_t        row_index,
  output logic                 last_row
);
  import mvm_pkg::*;

  localparam int PW = $clog2(MAX_N);
  localparam int NW = PW + 1;
  localparam logic [NW-1:0] MAX_N_W = NW'(MAX_N);

  value_t          vec_mem [MAX_N];
  size_t           size_in_use;
  logic [PW-1:0]   load_pos;
  logic [PW-1:0]   col_pos;
  logic [PW-1:0]   row_pos;
  value_t          running_sum;
  value_t          held_value;
  value_t          vec_data;
  value_t          product;
  logic [NW-1:0]   n_eff;
  logic [NW-1:0]   n_last;
  value_t          sum_next;
  logic            last_load;
  logic            last_rowpos;

  // zero acts as order one, anything past the memory depth as the full depth
  always_comb begin
    if (size_in_use == '0) n_eff = NW'(1);
    else if (32'(size_in_use) > MAX_N) n_eff = MAX_N_W;
    else n_eff = NW'(size_in_use);
  end

  assign n_last      = n_eff - NW'(1);
  assign last_load   = ({1'b0, load_pos} == n_last);
  assign last_rowpos = ({1'b0, row_pos} == n_last);
  assign sum_next    = running_sum + product;

  assign status.matrix_item = (item_mode == MODE_MATRIX);
  assign status.last_col    = ({1'b0, col_pos} == n_last);

  always_ff @(posedge clk) begin
    if (cmd.capture && item_mode == MODE_LOAD) vec_mem[load_pos] <= item_value;
    if (cmd.capture && item_mode == MODE_MATRIX) begin
      vec_data   <= vec_mem[col_pos];
      held_value <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.multiply) product <= held_value * vec_data;
    if (cmd.emit) begin
      result_value <= sum_next;
      row_index    <= ROW_W'(row_pos);
      last_row     <= last_rowpos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
      load_pos    <= '0;
      col_pos     <= '0;
      row_pos     <= '0;
      running_sum <= '0;
    end else if (cfg_write) begin
      size_in_use <= cfg_data;
      load_pos    <= '0;
      col_pos     <= '0;
      row_pos     <= '0;
      running_sum <= '0;
    end else begin
      if (cmd.capture && item_mode == MODE_LOAD) begin
        load_pos <= last_load ? '0 : load_pos + PW'(1);
      end
      if (cmd.accumulate) begin
        running_sum <= sum_next;
        col_pos     <= col_pos + PW'(1);
      end
      if (cmd.emit) begin
        running_sum <= '0;
        col_pos     <= '0;
        row_pos     <= last_rowpos ? '0 : row_pos + PW'(1);
      end
    end
  end

endmodule

FILE: hdl/mvm_checker.sv
// mvm_checker: port-level assertions for matrix_vector_multiply, attached by bind
// depends on mvm_pkg and on the top level's port signals
`timescale 1ns / 1ps

module mvm_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_ready,
  input logic            item_mode,
  input logic            result_valid,
  input logic            result_ready,
  input mvm_pkg::value_t result_value,
  input mvm_pkg::row_t   row_index,
  input logic            last_row
);
  import mvm_pkg::*;

  // a stalled row result keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_value) && $stable(row_index) && $stable(last_row))
    else $error("result changed while stalled");

  // a matrix request keeps the input closed through multiply and add
  a_matrix_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_mode == MODE_MATRIX |=> !item_ready ##1 !item_ready)
    else $error("input reopened during a matrix request");

  // a row result only appears out of the add step, never straight after idle
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(item_ready))
    else $error("result appeared without an add step");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_mode    (item.mode),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_value (result.result_value),
  .row_index    (result.row_index),
  .last_row     (result.last_row)
);

FILE: test/tb_matrix_vector_multiply.sv
// tb_matrix_vector_multiply: self-checking bench for the streamed matrix vector multiplier
// depends on mvm_pkg, mvm_if and matrix_vector_multiply; a directed table, a full-order phase, then random
// phases checked against a behavioral model of the row sums
`timescale 1ns / 1ps

module tb_matrix_vector_multiply;
  import mvm_pkg::*;

  localparam int MAX_N = 512;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_REQUESTS = 350;
  localparam int FULL_ORDER_MATRIX = 8;
  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam value_t VAL_NEG1 = 32'shFFFF_FFFF;

  typedef struct packed {
    value_t sum;
    row_t   row;
    logic   last;
  } row_result_t;

  typedef enum logic {STEP_CFG, STEP_REQ} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic       mode;
    value_t     value;
    logic       typed;
    value_t     sum;
    row_t       row;
    logic       last;
  } directed_step_t;

  localparam int DIRECTED_STEPS = 25;

  // typed rows carry the row sum that follows at a glance; the rest use the model
  directed_step_t directed_steps [DIRECTED_STEPS] = '{
    '{STEP_REQ, MODE_LOAD,   32'sd7,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, 32'sd3,   1'b0, '0,       '0,   1'b0},
    '{STEP_CFG, MODE_LOAD,   32'sd1,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_LOAD,   32'sd3,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, 32'sd5,   1'b1, 32'sd15,  9'd0, 1'b1},
    '{STEP_REQ, MODE_LOAD,   VAL_NEG1, 1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, VAL_NEG1, 1'b1, 32'sd1,   9'd0, 1'b1},
    '{STEP_REQ, MODE_LOAD,   VAL_MIN,  1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, VAL_MIN,  1'b1, 32'sd0,   9'd0, 1'b1},
    '{STEP_REQ, MODE_LOAD,   VAL_MAX,  1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, VAL_MAX,  1'b1, 32'sd1,   9'd0, 1'b1},
    '{STEP_REQ, MODE_LOAD,   VAL_NEG1, 1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, VAL_MIN,  1'b1, VAL_MIN,  9'd0, 1'b1},
    '{STEP_CFG, MODE_LOAD,   32'sd0,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_LOAD,   32'sd2,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, 32'sd2,   1'b1, 32'sd4,   9'd0, 1'b1},
    '{STEP_CFG, MODE_LOAD,   32'sd2,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_LOAD,   32'sd1,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_LOAD,   32'sd2,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, 32'sd3,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, 32'sd4,   1'b1, 32'sd11,  9'd0, 1'b0},
    '{STEP_REQ, MODE_MATRIX, 32'sd1,   1'b0, '0,       '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, 32'sd1,   1'b1, 32'sd3,   9'd1, 1'b1},
    '{STEP_CFG, MODE_LOAD,   32'sd1023, 1'b0, '0,      '0,   1'b0},
    '{STEP_REQ, MODE_MATRIX, 32'sd9,   1'b0, '0,       '0,   1'b0}
  };

  logic  clk;
  logic  rst;
  logic  cfg_write;
  size_t cfg_data;

  mvm_item_if   req_bus ();
  mvm_result_if row_bus ();

  matrix_vector_multiply #(.MAX_N(MAX_N)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .item      (req_bus),
    .result    (row_bus)
  );

  // model state of the multiplier
  logic [31:0] vec_image [MAX_N];
  bit          vec_loaded [MAX_N];
  int unsigned fill_ptr;
  int unsigned col_ptr;
  int unsigned row_ptr;
  logic [31:0] row_acc;
  size_t       order_reg;

  row_result_t pending_rows [$];
  bit          steady_flow;
  int unsigned n_requests;
  int unsigned n_configs;
  int unsigned n_rows_checked;
  int unsigned n_mismatch;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("timeout: run did not reach its end");
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned order_of(input size_t s);
    if (s == 0) return 1;
    if (s > MAX_N) return MAX_N;
    return 32'(s);
  endfunction

  function automatic value_t rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'sd1;
      2: return VAL_NEG1;
      3: return VAL_MIN;
      4: return VAL_MAX;
      default: return value_t'($urandom);
    endcase
  endfunction

  // one request of the row-major stream: a vector load or a multiply-accumulate step
  task automatic predict_request(input logic m, input value_t v, output bit has_row,
                                 output row_result_t row_out);
    int unsigned n;
    int unsigned pos;
    int unsigned col;
    int unsigned row;
    logic [31:0] operand;
    logic [31:0] prod;
    bit          last;
    n = order_of(order_reg);
    has_row = 1'b0;
    row_out = '0;
    operand = v;
    if (m == MODE_LOAD) begin
      pos = (fill_ptr >= n) ? 0 : fill_ptr;
      vec_image[pos] = operand;
      vec_loaded[pos] = 1'b1;
      fill_ptr = (pos + 1 >= n) ? 0 : pos + 1;
    end else begin
      col = (col_ptr >= n) ? n - 1 : col_ptr;
      row = (row_ptr >= n) ? n - 1 : row_ptr;
      prod = operand * vec_image[col];
      row_acc = row_acc + prod;
      if (col + 1 < n) begin
        col_ptr = col + 1;
      end else begin
        last = (row + 1 >= n);
        has_row = 1'b1;
        row_out.sum = row_acc;
        row_out.row = row_t'(row);
        row_out.last = last;
        row_acc = '0;
        col_ptr = 0;
        row_ptr = last ? 0 : row + 1;
      end
    end
  endtask

  task automatic send_request(input logic m, input value_t v);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.mode <= m;
    req_bus.value <= v;
    do @(posedge clk); while (!req_bus.ready);
    n_requests++;
  endtask

  // matrix requests only ever read vector entries that were loaded
  task automatic issue(input logic m, input value_t v);
    logic        mode_sel;
    bit          has_row;
    row_result_t r;
    mode_sel = m;
    if (mode_sel == MODE_MATRIX && !vec_loaded[col_ptr % MAX_N]) mode_sel = MODE_LOAD;
    send_request(mode_sel, v);
    predict_request(mode_sel, v, has_row, r);
    if (has_row) pending_rows.push_back(r);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_rows.size() != 0);
  endtask

  task automatic do_config(input size_t s);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= s;
    @(posedge clk);
    cfg_write <= 1'b0;
    order_reg = s;
    fill_ptr = 0;
    col_ptr = 0;
    row_ptr = 0;
    row_acc = '0;
    n_configs++;
  endtask

  // result side: random stalls unless steady_flow is set, compare against the oldest expected row sum
  initial begin
    int unsigned stall;
    row_result_t want;
    row_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        row_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      row_bus.ready <= 1'b1;
      do @(posedge clk); while (!row_bus.valid);
      if (pending_rows.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected row sum: sum %0d row %0d last %0b",
                   row_bus.result_value, row_bus.row_index, row_bus.last_row);
      end else begin
        want = pending_rows.pop_front();
        n_rows_checked++;
        if (row_bus.result_value !== want.sum || row_bus.row_index !== want.row ||
            row_bus.last_row !== want.last) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("row mismatch: expected sum %0d row %0d last %0b, got sum %0d row %0d last %0b",
                     want.sum, want.row, want.last,
                     row_bus.result_value, row_bus.row_index, row_bus.last_row);
        end
      end
    end
  end

  initial begin
    int unsigned    n;
    int unsigned    loads;
    int unsigned    rows;
    int unsigned    rand_requests;
    bit             has_row;
    bit             shaped;
    row_result_t    r;
    directed_step_t st;
    size_t          s;

    order_reg = SIZE_RESET;
    fill_ptr = 0;
    col_ptr = 0;
    row_ptr = 0;
    row_acc = '0;
    foreach (vec_loaded[i]) vec_loaded[i] = 1'b0;
    steady_flow = 1'b0;
    n_requests = 0;
    n_configs = 0;
    n_rows_checked = 0;
    n_mismatch = 0;

    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    req_bus.valid <= 1'b0;
    req_bus.mode <= MODE_LOAD;
    req_bus.value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_STEPS; i++) begin
      st = directed_steps[i];
      if (st.kind == STEP_CFG) begin
        do_config(size_t'(st.value));
      end else begin
        send_request(st.mode, st.value);
        predict_request(st.mode, st.value, has_row, r);
        if (st.typed) pending_rows.push_back('{st.sum, st.row, st.last});
        else if (has_row) pending_rows.push_back(r);
      end
    end

    // full order: load every vector entry, then the start of a row
    do_config(SIZE_RESET);
    steady_flow = 1'b1;
    repeat (MAX_N) issue(MODE_LOAD, rand_word());
    repeat (FULL_ORDER_MATRIX) issue(MODE_MATRIX, rand_word());
    steady_flow = 1'b0;

    rand_requests = 0;
    while (rand_requests < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 19))
        0:       s = '0;
        1:       s = 10'd1;
        2:       s = SIZE_RESET;
        3:       s = size_t'($urandom_range(513, 1023));
        4, 5:    s = size_t'($urandom_range(9, 24));
        default: s = size_t'($urandom_range(2, 8));
      endcase
      do_config(s);
      steady_flow = ($urandom_range(0, 3) == 0);
      n = order_of(s);
      if (n > 24) begin
        // large orders: a short mixed stream that never finishes a row
        repeat (30) begin
          issue(logic'($urandom_range(0, 1)), rand_word());
          rand_requests++;
        end
      end else begin
        shaped = ($urandom_range(0, 4) != 0);
        loads = shaped ? n : $urandom_range(0, n);
        repeat (loads) begin
          issue(MODE_LOAD, rand_word());
          rand_requests++;
        end
        rows = $urandom_range(1, n + 1);
        repeat (rows * n) begin
          if (!shaped && $urandom_range(0, 9) == 0) begin
            issue(MODE_LOAD, rand_word());
            rand_requests++;
          end
          issue(MODE_MATRIX, rand_word());
          rand_requests++;
        end
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    $display("covered %0d requests over %0d order settings (0, 1, small, 512, above 512)",
             n_requests, n_configs);
    $display("checked %0d row sums, %0d mismatches", n_rows_checked, n_mismatch);
    if (n_mismatch == 0 && pending_rows.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
